@@ design/ladlp_pkg.sv @@
// Package: control word layout, microcode program and fixed coefficients of the ladder filter.
`default_nettype none

package ladlp_pkg;

    // Q.16 coefficients
    localparam int unsigned K_F     = 76022;  // 1.16
    localparam int unsigned K_GAIN  = 22946;  // 0.35013
    localparam int unsigned K_FB    = 9830;   // 0.15
    localparam int unsigned K_ZERO  = 19661;  // 0.3

    // coefficient operand width of the shared multiplier (signed)
    localparam int B_W = 19;

    localparam int N_POLES = 4;
    localparam logic [1:0] LAST_POLE = 2'(N_POLES - 1);

    typedef logic [4:0] t_pc;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MLO,     // acc = low half of a times b, plus rounding half
        OP_MHI,     // acc += high half of a times b, shifted up
        OP_WF,      // f, and 1 - f
        OP_WF2,
        OP_WF4,
        OP_WG,
        OP_WK,      // k = 1 - product
        OP_WFB,
        OP_XSUB,    // x = scaled sample - product
        OP_XSAT,    // x = sat(product), pole index cleared
        OP_YSET,    // y = x + product
        OP_YEND,    // x = sat(y + product), pole state written, next pole
        OP_DONE     // result to output register
    } t_op;

    typedef enum logic [3:0] {
        A_CUTOFF,
        A_F,
        A_F2,
        A_F4,
        A_RES4,
        A_OUT3,
        A_IN,
        A_OUT,
        A_X
    } t_asel;

    typedef enum logic [3:0] {
        B_KF,
        B_F,
        B_F2,
        B_KGAIN,
        B_KFB,
        B_K,
        B_FB,
        B_G,
        B_KZERO,
        B_OMF
    } t_bsel;

    typedef enum logic {
        JC_NONE,
        JC_NOT_LAST   // jump while the current pole is not the last
    } t_jc;

    typedef struct packed {
        t_op   op;
        t_asel a_sel;
        t_bsel b_sel;
        t_jc   jc;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic last_pole;
        logic out_stall;
    } t_stat;

    localparam t_pc LOOP_PC = 5'd24;

    function automatic t_ctrl cw(input t_op op, input t_asel a, input t_bsel b);
        t_ctrl c;
        c.op     = op;
        c.a_sel  = a;
        c.b_sel  = b;
        c.jc     = JC_NONE;
        c.target = '0;
        return c;
    endfunction

    // microcode program
    function automatic t_ctrl ucode(input t_pc pc);
        t_ctrl c;
        case (pc)
            5'd0:  c = cw(OP_MLO,  A_CUTOFF, B_KF);
            5'd1:  c = cw(OP_MHI,  A_CUTOFF, B_KF);
            5'd2:  c = cw(OP_WF,   A_X,      B_G);
            5'd3:  c = cw(OP_MLO,  A_F,      B_F);
            5'd4:  c = cw(OP_MHI,  A_F,      B_F);
            5'd5:  c = cw(OP_WF2,  A_X,      B_G);
            5'd6:  c = cw(OP_MLO,  A_F2,     B_F2);
            5'd7:  c = cw(OP_MHI,  A_F2,     B_F2);
            5'd8:  c = cw(OP_WF4,  A_X,      B_G);
            5'd9:  c = cw(OP_MLO,  A_F4,     B_KGAIN);
            5'd10: c = cw(OP_MHI,  A_F4,     B_KGAIN);
            5'd11: c = cw(OP_WG,   A_X,      B_G);
            5'd12: c = cw(OP_MLO,  A_F2,     B_KFB);
            5'd13: c = cw(OP_MHI,  A_F2,     B_KFB);
            5'd14: c = cw(OP_WK,   A_X,      B_G);
            5'd15: c = cw(OP_MLO,  A_RES4,   B_K);
            5'd16: c = cw(OP_MHI,  A_RES4,   B_K);
            5'd17: c = cw(OP_WFB,  A_X,      B_G);
            5'd18: c = cw(OP_MLO,  A_OUT3,   B_FB);
            5'd19: c = cw(OP_MHI,  A_OUT3,   B_FB);
            5'd20: c = cw(OP_XSUB, A_X,      B_G);
            5'd21: c = cw(OP_MLO,  A_X,      B_G);
            5'd22: c = cw(OP_MHI,  A_X,      B_G);
            5'd23: c = cw(OP_XSAT, A_X,      B_G);
            5'd24: c = cw(OP_MLO,  A_IN,     B_KZERO);
            5'd25: c = cw(OP_MHI,  A_IN,     B_KZERO);
            5'd26: c = cw(OP_YSET, A_X,      B_G);
            5'd27: c = cw(OP_MLO,  A_OUT,    B_OMF);
            5'd28: c = cw(OP_MHI,  A_OUT,    B_OMF);
            5'd29: begin
                c = cw(OP_YEND, A_X, B_G);
                c.jc     = JC_NOT_LAST;
                c.target = LOOP_PC;
            end
            5'd30: c = cw(OP_DONE, A_X,      B_G);
            default: c = cw(OP_NOP, A_X,     B_G);
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/ladlp_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module ladlp_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire ladlp_pkg::t_stat  i_stat,
    output ladlp_pkg::t_ctrl       o_ctrl,
    output logic                   o_busy
);
    import ladlp_pkg::*;

    logic  r_busy, n_busy;
    t_pc   r_pc, n_pc;
    t_ctrl word;

    assign word = ucode(r_pc);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (!r_busy) begin
            if (i_start) begin
                n_busy = 1'b1;
                n_pc   = '0;
            end
        end else begin
            case (word.op)
                OP_DONE: begin
                    if (!i_stat.out_stall) begin
                        n_busy = 1'b0;
                    end
                end
                default: begin
                    if (word.jc == JC_NOT_LAST && !i_stat.last_pole) begin
                        n_pc = word.target;
                    end else begin
                        n_pc = r_pc + 5'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    always_comb begin
        o_ctrl = word;
        if (!r_busy) begin
            o_ctrl = cw(OP_NOP, A_X, B_G);
        end
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

@@ design/four_pole_ladder_lowpass_unit.sv @@
// Top level: four-pole ladder low-pass filter, microcoded over one shared multiplier.
`default_nettype none

// Four-pole ladder low-pass filter. Each input word carries a Q1.15 sample
// (SAMPLE_BITS wide) with its own Q0.16 cutoff and Q2.14 resonance; each
// output word is the fourth pole's output, rounded and saturated to the
// sample format. Internally f = 1.16*cutoff, gain = 0.35013*f^4 and
// feedback = resonance*(1 - 0.15*f^2) are formed per sample, the gained and
// fed-back sample then runs through four one-pole sections
// y = x + 0.3*x_prev + (1-f)*y_prev, all in Q6.(STATE_BITS-6) fixed point with
// round-half-up products and saturation of every section output.
// A new word is taken in the cycle after the previous result is registered
// into the output register. The pace is set by the single multiplier:
// sixteen products per sample, each made in two passes (low and high half
// of the wide operand), plus register moves, stepped by a 31-entry
// microcode table with a loop over the four poles.
// A finished result sits in an output register, so the next word is
// accepted while the previous result is still waiting; a new result is only
// blocked if the old one has not been taken by then. Reset clears the filter
// memory (all eight pole values).
module four_pole_ladder_lowpass_unit #(
    parameter int SAMPLE_BITS = 16,
    parameter int STATE_BITS  = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input words
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    input  wire logic        [15:0]            i_cutoff,
    input  wire logic        [15:0]            i_resonance,
    // output words
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed      [SAMPLE_BITS-1:0] o_sample_out
);
    import ladlp_pkg::*;

    // widths
    localparam int SB   = SAMPLE_BITS;
    localparam int S    = STATE_BITS;
    localparam int AW   = S + 3;               // wide multiplier operand
    localparam int HALF = (AW + 1) / 2;        // low pass of the wide operand
    localparam int PW   = AW + B_W;            // product accumulator
    localparam int QW   = PW - 16;             // product after the Q.16 scaling
    // fraction bits of state minus fraction bits of a sample
    localparam int DIFF = (S - 6) - (SB - 1);
    localparam int DSH  = (DIFF >= 0) ? DIFF : -DIFF;
    localparam int RSH  = (DSH > 0) ? DSH - 1 : 0;
    localparam int IW   = ((SB > AW) ? SB : AW) + 1;
    localparam int RW   = S + DSH + 1;

    localparam logic signed [PW-1:0] RND_Q16 = PW'(32768);
    localparam logic signed [IW-1:0] RND_IN  = {{(IW-1){1'b0}}, 1'b1} << RSH;
    localparam logic signed [RW-1:0] RND_OUT = {{(RW-1){1'b0}}, 1'b1} << RSH;
    localparam logic signed [QW-1:0] ST_MAX  = {{(QW-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [QW-1:0] ST_MIN  = {{(QW-S+1){1'b1}}, {(S-1){1'b0}}};
    localparam logic signed [RW-1:0] SM_MAX  = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [RW-1:0] SM_MIN  = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic [16:0]          ONE_Q16 = 17'h10000;
    localparam logic signed [B_W-1:0] ONE_B  = B_W'(65536);

    function automatic logic signed [S-1:0] sat_state(input logic signed [QW-1:0] v);
        logic signed [QW-1:0] t;
        t = v;
        if (v > ST_MAX) begin
            t = ST_MAX;
        end else if (v < ST_MIN) begin
            t = ST_MIN;
        end
        return t[S-1:0];
    endfunction

    // sequencer
    t_ctrl ctrl;
    t_stat stat;
    logic  busy;
    logic  in_acc;

    assign o_in_ready = !busy;
    assign in_acc     = i_in_valid && !busy;

    ladlp_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_busy  (busy)
    );

    // captured input word
    logic signed [SB-1:0] r_sample;
    logic        [15:0]   r_cutoff;
    logic        [15:0]   r_res;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample_in;
            r_cutoff <= i_cutoff;
            r_res    <= i_resonance;
        end
    end

    // per-sample coefficients
    logic        [16:0]    r_f, r_f2, r_f4, r_k;
    logic        [15:0]    r_g;
    logic        [17:0]    r_fb;
    logic signed [B_W-1:0] r_omf;   // 1 - f, may go negative

    // pole memory and working values
    logic signed [S-1:0]  r_in_prev  [N_POLES];
    logic signed [S-1:0]  r_out_prev [N_POLES];
    logic signed [AW-1:0] r_x;
    logic signed [QW-1:0] r_y;
    logic        [1:0]    r_i;
    logic signed [PW-1:0] r_acc, n_acc;

    // operand select
    logic signed [AW-1:0]  a_op;
    logic signed [B_W-1:0] b_op;

    always_comb begin
        case (ctrl.a_sel)
            A_CUTOFF: a_op = signed'(AW'(r_cutoff));
            A_F:      a_op = signed'(AW'(r_f));
            A_F2:     a_op = signed'(AW'(r_f2));
            A_F4:     a_op = signed'(AW'(r_f4));
            A_RES4:   a_op = signed'(AW'({r_res, 2'b00}));
            A_OUT3:   a_op = AW'(r_out_prev[LAST_POLE]);
            A_IN:     a_op = AW'(r_in_prev[r_i]);
            A_OUT:    a_op = AW'(r_out_prev[r_i]);
            A_X:      a_op = r_x;
            default:  a_op = r_x;
        endcase
    end

    always_comb begin
        case (ctrl.b_sel)
            B_KF:    b_op = signed'(B_W'(K_F));
            B_F:     b_op = signed'({2'b00, r_f});
            B_F2:    b_op = signed'({2'b00, r_f2});
            B_KGAIN: b_op = signed'(B_W'(K_GAIN));
            B_KFB:   b_op = signed'(B_W'(K_FB));
            B_K:     b_op = signed'({2'b00, r_k});
            B_FB:    b_op = signed'({1'b0, r_fb});
            B_G:     b_op = signed'({3'b000, r_g});
            B_KZERO: b_op = signed'(B_W'(K_ZERO));
            B_OMF:   b_op = r_omf;
            default: b_op = r_omf;
        endcase
    end

    // shared multiplier: wide operand split in two passes
    logic signed [HALF:0]           lo_s;
    logic signed [AW-HALF-1:0]      hi_s;
    logic signed [HALF+B_W:0]       p_lo;
    logic signed [AW-HALF+B_W-1:0]  p_hi;
    logic signed [QW-1:0]           q;

    assign lo_s = signed'({1'b0, a_op[HALF-1:0]});
    assign hi_s = a_op[AW-1:HALF];
    assign p_lo = lo_s * b_op;
    assign p_hi = hi_s * b_op;
    assign q    = signed'(r_acc[PW-1:16]);   // round-half-up a*b/2^16

    always_comb begin
        n_acc = r_acc;
        case (ctrl.op)
            OP_MLO:  n_acc = PW'(p_lo) + RND_Q16;
            OP_MHI:  n_acc = r_acc + (PW'(p_hi) <<< HALF);
            default: n_acc = r_acc;
        endcase
    end

    // sample moved into state format
    logic signed [IW-1:0] x_wide;
    logic signed [AW-1:0] x0;

    always_comb begin
        if (DIFF >= 0) begin
            x_wide = IW'(r_sample) <<< DSH;
        end else begin
            x_wide = (IW'(r_sample) + RND_IN) >>> DSH;
        end
        x0 = x_wide[AW-1:0];
    end

    // section output, summed and clamped
    logic signed [QW-1:0] y_sum;
    logic signed [S-1:0]  y_sat;

    assign y_sum = r_y + q;
    assign y_sat = sat_state(y_sum);

    // result back to sample format
    logic signed [S-1:0]  y_last;
    logic signed [RW-1:0] res_wide;
    logic signed [RW-1:0] res_clamp;
    logic signed [SB-1:0] res;

    always_comb begin
        y_last = r_x[S-1:0];
        if (DIFF > 0) begin
            res_wide = (RW'(y_last) + RND_OUT) >>> DSH;
        end else begin
            res_wide = RW'(y_last) <<< DSH;
        end
        res_clamp = res_wide;
        if (res_wide > SM_MAX) begin
            res_clamp = SM_MAX;
        end else if (res_wide < SM_MIN) begin
            res_clamp = SM_MIN;
        end
        res = res_clamp[SB-1:0];
    end

    // output register
    logic                 r_out_valid;
    logic signed [SB-1:0] r_out;
    logic                 out_stall;
    logic                 done;

    assign out_stall      = r_out_valid && !i_out_ready;
    assign done           = (ctrl.op == OP_DONE) && !out_stall;
    assign stat.out_stall = out_stall;
    assign stat.last_pole = (r_i == LAST_POLE);

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        case (ctrl.op)
            OP_WF: begin
                r_f   <= q[16:0];
                r_omf <= ONE_B - signed'({2'b00, q[16:0]});
            end
            OP_WF2:  r_f2 <= q[16:0];
            OP_WF4:  r_f4 <= q[16:0];
            OP_WG:   r_g  <= q[15:0];
            OP_WK:   r_k  <= ONE_Q16 - q[16:0];
            OP_WFB:  r_fb <= q[17:0];
            OP_XSUB: r_x  <= AW'(QW'(x0) - q);
            OP_XSAT: r_x  <= AW'(sat_state(q));
            OP_YSET: r_y  <= QW'(r_x) + q;
            OP_YEND: r_x  <= AW'(y_sat);
            default: r_x  <= r_x;
        endcase
        if (done) begin
            r_out <= res;
        end
    end

    // pole memory, pole index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < N_POLES; n++) begin
                r_in_prev[n]  <= '0;
                r_out_prev[n] <= '0;
            end
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (ctrl.op)
                OP_XSAT: r_i <= '0;
                OP_YEND: begin
                    r_in_prev[r_i]  <= r_x[S-1:0];
                    r_out_prev[r_i] <= y_sat;
                    r_i             <= r_i + 2'd1;
                end
                default: r_i <= r_i;
            endcase
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule

`default_nettype wire

@@ dv/four_pole_ladder_lowpass_unit_tb.sv @@
// Testbench: random and directed sample words through the ladder filter, checked against a fixed-point predictor.
`timescale 1ns / 1ps

module four_pole_ladder_lowpass_unit_tb;
    import ladlp_pkg::*;

    localparam int SAMPLE_BITS  = 16;
    localparam int STATE_BITS   = 32;
    // sample Q1.15 -> state Q6.26
    localparam int FRAC_GAP     = (STATE_BITS - 6) - (SAMPLE_BITS - 1);
    localparam int RANDOM_WORDS = 950;
    // limit allows for the longest input gaps and receiver stalls
    localparam int CYCLE_LIMIT  = 1200000;
    localparam int TAIL_CYCLES  = 100;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic        [15:0]            cutoff;
        logic        [15:0]            resonance;
        bit                            drain_first;  // hold until all results are back
    } t_filter_word;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in  = '0;
    logic        [15:0]            i_cutoff     = '0;
    logic        [15:0]            i_resonance  = '0;
    logic                          i_out_ready  = 1'b0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;

    t_filter_word                  pending_words[$];
    logic signed [SAMPLE_BITS-1:0] expected_samples[$];

    // filter memory of the predictor, Q6.26
    longint pole_in_mem[4];
    longint pole_out_mem[4];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int burst_left     = 1;
    int gap_left       = 0;
    int rx_mode        = 0;
    int rx_mode_left   = 0;
    int stall_left     = 0;

    four_pole_ladder_lowpass_unit #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .STATE_BITS (STATE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_in (i_sample_in),
        .i_cutoff    (i_cutoff),
        .i_resonance (i_resonance),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_sample_out(o_sample_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // a * b / 2^16, rounded half up (floor after adding one half)
    function automatic longint mul_round_q16(input longint a, input longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    // Runs one word through the four poles, updates the filter memory and
    // returns the rounded, saturated fourth-pole output.
    function automatic logic signed [SAMPLE_BITS-1:0] predict_pole_output(
        input logic signed [SAMPLE_BITS-1:0] sample,
        input logic        [15:0]            cutoff,
        input logic        [15:0]            resonance
    );
        longint f;
        longint f2;
        longint f4;
        longint gain;
        longint k;
        longint fb;
        longint one_minus_f;
        longint x;
        longint y;
        longint result;
        // coefficients are all non-negative: plain rounded shifts
        f           = (longint'(cutoff) * longint'(K_F) + 32768) >>> 16;
        f2          = (f * f + 32768) >>> 16;
        f4          = (f2 * f2 + 32768) >>> 16;
        gain        = (f4 * longint'(K_GAIN) + 32768) >>> 16;
        k           = 65536 - ((f2 * longint'(K_FB) + 32768) >>> 16);
        fb          = (longint'(resonance) * k + 8192) >>> 14;
        // goes negative once f passes one (cutoff near full scale)
        one_minus_f = 65536 - f;

        x = longint'(sample) * (64'sd1 <<< FRAC_GAP);
        x = x - mul_round_q16(pole_out_mem[3], fb);
        x = clamp_signed(mul_round_q16(x, gain), STATE_BITS);
        y = x;
        for (int p = 0; p < 4; p++) begin
            y = x + mul_round_q16(pole_in_mem[p], longint'(K_ZERO))
                  + mul_round_q16(pole_out_mem[p], one_minus_f);
            y = clamp_signed(y, STATE_BITS);
            pole_in_mem[p]  = x;
            pole_out_mem[p] = y;
            x = y;
        end
        result = (y + (64'sd1 <<< (FRAC_GAP - 1))) >>> FRAC_GAP;
        result = clamp_signed(result, SAMPLE_BITS);
        return result[SAMPLE_BITS-1:0];
    endfunction

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents words from pending_words in bursts with gaps.
    // The expected output is computed at the edge where a word is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : word_driver
        t_filter_word w;
        logic         next_valid;
        next_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                expected_samples.push_back(
                    predict_pole_output(i_sample_in, i_cutoff, i_resonance));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].drain_first && expected_samples.size() != 0)) begin
                    w = pending_words.pop_front();
                    i_sample_in <= w.sample;
                    i_cutoff    <= w.cutoff;
                    i_resonance <= w.resonance;
                    next_valid  = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        // back-to-back bursts a quarter of the time
                        burst_left = $urandom_range(1, 40);
                        if ($urandom_range(0, 3) == 0) begin
                            gap_left = 0;
                        end else if ($urandom_range(0, 2) == 0) begin
                            gap_left = $urandom_range(1, 120);
                        end else begin
                            gap_left = $urandom_range(1, 30);
                        end
                    end
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken output word against the oldest
    // expectation and drives the receiver's stall pattern.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        logic signed [SAMPLE_BITS-1:0] want;
        logic                          next_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                log_mismatch($sformatf("output word %0d with nothing expected", o_sample_out));
            end else begin
                want = expected_samples.pop_front();
                if (o_sample_out !== want) begin
                    log_mismatch($sformatf("sample_out expected %0d, got %0d",
                                           want, o_sample_out));
                end
            end
        end

        // mode 0: always ready, 1: scattered stalls, 2: rare long stalls
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(100, 400);
        end else begin
            rx_mode_left--;
        end
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else begin
            case (rx_mode)
                0: begin
                    next_ready = 1'b1;
                end
                1: begin
                    next_ready = ($urandom_range(0, 2) != 0);
                end
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(1, 64);
                        next_ready = 1'b0;
                    end else begin
                        next_ready = 1'b1;
                    end
                end
            endcase
        end
        i_out_ready <= next_ready;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_word(input logic signed [SAMPLE_BITS-1:0] s, input logic [15:0] c,
                            input logic [15:0] r, input bit drain);
        t_filter_word w;
        w.sample      = s;
        w.cutoff      = c;
        w.resonance   = r;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // low cutoffs barely pass anything, high ones push f above one
    function automatic logic [15:0] pick_cutoff();
        case ($urandom_range(0, 4))
            0:       return 16'($urandom_range(0, 4000));
            1:       return 16'($urandom_range(50000, 65535));
            2:       return 16'($urandom_range(12000, 40000));
            default: return 16'($urandom);
        endcase
    endfunction

    // nominal range most of the time, some above it (up to just under 4)
    function automatic logic [15:0] pick_resonance();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom_range(0, 16384));
            1:       return 16'($urandom_range(49152, 65535));
            default: return 16'($urandom_range(0, 49152));
        endcase
    endfunction

    initial begin : stimulus
        int                            n_random;
        int                            len;
        int                            mode;
        int                            amp;
        int                            period;
        bit                            jitter;
        bit                            drain;
        logic        [15:0]            co;
        logic        [15:0]            rs;
        logic signed [SAMPLE_BITS-1:0] s;

        for (int p = 0; p < 4; p++) begin
            pole_in_mem[p]  = 0;
            pole_out_mem[p] = 0;
        end

        // Directed: field extremes, cutoff at zero and full scale, resonance
        // past its nominal range so the loop rings into saturation.
        add_word(16'sd0, 16'd0, 16'd0, 1'b0);
        repeat (3) add_word(16'sd32767, 16'd65535, 16'd0, 1'b0);
        repeat (2) add_word(-16'sd32768, 16'd65535, 16'd0, 1'b0);
        add_word(16'sd12345, 16'd0, 16'd49152, 1'b0);
        add_word(-16'sd1, 16'd32768, 16'd49152, 1'b0);
        add_word(16'sd1, 16'd1, 16'd1, 1'b0);
        repeat (4) add_word(16'sd32767, 16'd65535, 16'd65535, 1'b0);
        repeat (4) add_word(-16'sd32768, 16'd65535, 16'd65535, 1'b0);
        repeat (3) add_word(16'sd32767, 16'd45000, 16'd65535, 1'b0);
        add_word(-16'sd32768, 16'd0, 16'd65535, 1'b0);
        add_word(16'sd0, 16'd65535, 16'd49152, 1'b0);

        // Random: phrases of steady cutoff and resonance with structured
        // sample patterns, so resonance can build up; some phrases jitter
        // the controls on every word.
        n_random = 0;
        while (n_random < RANDOM_WORDS) begin
            len    = $urandom_range(4, 60);
            co     = pick_cutoff();
            rs     = pick_resonance();
            mode   = $urandom_range(0, 3);
            amp    = $urandom_range(1, 32767);
            period = $urandom_range(1, 20);
            jitter = ($urandom_range(0, 4) == 0);
            // first phrase always waits for an empty pipe
            drain  = (n_random == 0) || ($urandom_range(0, 19) == 0);
            for (int j = 0; j < len; j++) begin
                if (jitter) begin
                    co = pick_cutoff();
                    rs = pick_resonance();
                end
                case (mode)
                    0:       s = SAMPLE_BITS'($urandom);
                    1:       s = ((j / period) % 2 != 0) ? SAMPLE_BITS'(amp) : SAMPLE_BITS'(-amp);
                    2:       s = SAMPLE_BITS'(int'($urandom_range(0, 1023)) - 512);
                    default: s = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                endcase
                add_word(s, co, rs, drain && (j == 0));
            end
            n_random += len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || i_in_valid || expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
        // let any stray output word show up
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
design/ladlp_pkg.sv
design/ladlp_seq.sv
design/four_pole_ladder_lowpass_unit.sv
dv/four_pole_ladder_lowpass_unit_tb.sv
